// File: design/bbsi_pkg.sv
// Package with the types and constants shared by the interpreter files.
`default_nettype none
package bbsi_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned TokenWidth = 8;
    localparam int unsigned PtrWidth = 8;

    typedef logic [WordWidth-1:0] word_t;
    typedef logic [TokenWidth-1:0] token_t;
    typedef logic [PtrWidth-1:0] ptr_t;

    // Character codes with a meaning of their own.
    localparam token_t TokEnd = 8'h00;
    localparam token_t TokBang = 8'h21;
    localparam token_t TokZero = 8'h30;
    localparam token_t TokNine = 8'h39;
    localparam token_t TokUpA = 8'h41;
    localparam token_t TokUpF = 8'h46;
    localparam token_t OpTime = 8'h61;
    localparam token_t OpPut = 8'h62;
    localparam token_t OpDrop = 8'h63;
    localparam token_t OpMul = 8'h64;
    localparam token_t OpDiv = 8'h65;
    localparam token_t OpAdd = 8'h66;
    localparam token_t OpSub = 8'h67;
    localparam token_t OpMod = 8'h68;
    localparam token_t OpShl = 8'h6a;
    localparam token_t OpShr = 8'h6b;
    localparam token_t OpAnd = 8'h6c;
    localparam token_t OpOr = 8'h6d;
    localparam token_t OpXor = 8'h6e;
    localparam token_t OpNot = 8'h6f;
    localparam token_t OpDup = 8'h70;
    localparam token_t OpPick = 8'h71;
    localparam token_t OpSwap = 8'h72;
    localparam token_t OpLt = 8'h73;
    localparam token_t OpGt = 8'h74;
    localparam token_t OpEq = 8'h75;

    localparam word_t AllOnes = '1;
    localparam word_t ShiftMax = 32'd31;
    localparam word_t HexTen = 32'hA;
    localparam word_t ByteMask = 32'hff;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSHNUM,
        ST_RD_A,
        ST_RD_B,
        ST_EXEC,
        ST_DIV,
        ST_WR2,
        ST_OUT,
        ST_CLEAR
    } state_t;

endpackage
`default_nettype wire

// File: design/bbsi_stream_if.sv
// Valid/ready channel interfaces for tokens and samples.
`default_nettype none
interface bbsi_in_if;
    import bbsi_pkg::*;
    logic valid;
    logic ready;
    token_t token;
    word_t sample_time;
    modport source (output valid, output token, output sample_time, input ready);
    modport sink (input valid, input token, input sample_time, output ready);
endinterface

interface bbsi_out_if;
    logic valid;
    logic ready;
    logic [7:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

// File: design/bytebeat_stack_interpreter.sv
// Top level of the bytebeat stack interpreter with its stack memory.
// Digits and title characters are taken in the idle state; a stack operation reads its
// operands from the RAM and then writes, after a push of any pending number; divide and
// modulo run in the bit-serial divider. Timing is set by the one-read, one-write stack RAM.
// The end token returns the sample, then clears the RAM one word a cycle. After reset the
// same clearing pass runs before any word.
`default_nettype none
module bytebeat_stack_interpreter
    import bbsi_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 256
) (
    input wire logic clk,
    input wire logic rst_n,
    bbsi_in_if.sink in_ch,
    bbsi_out_if.source out_ch
);

    localparam int unsigned AddrWidth = $clog2(STACK_DEPTH);
    typedef logic [AddrWidth-1:0] addr_t;

    // Stack memory with registered read.
    word_t mem [STACK_DEPTH];
    word_t rdata;
    addr_t raddr;
    addr_t waddr;
    word_t wdata;
    logic we;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    state_t state_reg, state_next;
    ptr_t sp_reg, sp_next;
    word_t pend_reg, pend_next;
    logic pending_reg, pending_next;
    logic title_reg, title_next;
    token_t tok_reg, tok_next;
    word_t time_reg, time_next;
    word_t a_reg, a_next;
    word_t b_reg, b_next;
    logic [7:0] smp_reg, smp_next;
    logic oval_reg, oval_next;
    ptr_t clr_reg, clr_next;
    // Divider: remainder, quotient and step count.
    word_t rem_reg, rem_next;
    word_t quo_reg, quo_next;
    logic [5:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sp_reg <= '0;
            pending_reg <= 1'b0;
            title_reg <= 1'b1;
            oval_reg <= 1'b0;
            clr_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            pending_reg <= pending_next;
            title_reg <= title_next;
            oval_reg <= oval_next;
            clr_reg <= clr_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        time_reg <= time_next;
        a_reg <= a_next;
        b_reg <= b_next;
        smp_reg <= smp_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    // Maps the 8-bit pointer onto a RAM slot, the pointer modulo STACK_DEPTH, through a constant table.
    function automatic addr_t to_addr(input ptr_t p);
        addr_t r;
        r = '0;
        for (int i = 0; i < 2**PtrWidth; i++)
        begin
            if (p == ptr_t'(i))
            begin
                r = addr_t'(i % STACK_DEPTH);
            end
        end
        return r;
    endfunction

    // Arithmetic on the two popped words, divide and modulo excluded.
    word_t alu;
    always_comb
    begin
        case (tok_reg)
            OpMul: alu = b_reg * a_reg;
            OpAdd: alu = b_reg + a_reg;
            OpSub: alu = b_reg - a_reg;
            OpShl: alu = (a_reg > ShiftMax) ? '0 : (b_reg << a_reg[4:0]);
            OpShr: alu = (a_reg > ShiftMax) ? '0 : (b_reg >> a_reg[4:0]);
            OpAnd: alu = b_reg & a_reg;
            OpOr: alu = b_reg | a_reg;
            OpXor: alu = b_reg ^ a_reg;
            OpLt: alu = (b_reg < a_reg) ? AllOnes : '0;
            OpGt: alu = (b_reg > a_reg) ? AllOnes : '0;
            default: alu = (b_reg == a_reg) ? AllOnes : '0;
        endcase
    end

    // One restoring division step.
    logic [WordWidth:0] trial;
    word_t rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg[WordWidth-2:0], quo_reg[WordWidth-1]};
        trial = {1'b0, rem_sh} - {1'b0, a_reg};
    end

    logic is_digit, is_hex, is_binop;
    word_t digit_val;
    ptr_t pick_n;
    always_comb
    begin
        is_digit = (in_ch.token >= TokZero) && (in_ch.token <= TokNine);
        is_hex = (in_ch.token >= TokUpA) && (in_ch.token <= TokUpF);
        digit_val = is_digit ? word_t'(in_ch.token - TokZero)
                             : word_t'(in_ch.token - TokUpA) + HexTen;
        is_binop = 1'b0;
        case (tok_reg)
            OpMul, OpDiv, OpAdd, OpSub, OpMod, OpShl, OpShr, OpAnd, OpOr, OpXor,
            OpLt, OpGt, OpEq: is_binop = 1'b1;
            default: is_binop = 1'b0;
        endcase
        pick_n = ptr_t'((rdata + 32'd1) & ByteMask);
    end

    // Sequencer: most operations read operands through the RAM port, then write; drop does not write.
    always_comb
    begin
        state_next = state_reg;
        sp_next = sp_reg;
        pend_next = pend_reg;
        pending_next = pending_reg;
        title_next = title_reg;
        tok_next = tok_reg;
        time_next = time_reg;
        a_next = a_reg;
        b_next = b_reg;
        smp_next = smp_reg;
        oval_next = oval_reg;
        clr_next = clr_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        raddr = to_addr(sp_reg);
        waddr = to_addr(sp_reg);
        wdata = '0;
        we = 1'b0;
        in_ch.ready = 1'b0;

        if (out_ch.ready)
        begin
            oval_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    tok_next = in_ch.token;
                    time_next = in_ch.sample_time;
                    if (title_reg && (in_ch.token != TokEnd))
                    begin
                        if (in_ch.token == TokBang)
                        begin
                            title_next = 1'b0;
                        end
                    end
                    else if (in_ch.token == TokBang)
                    begin
                    end
                    else if (is_digit || is_hex)
                    begin
                        pend_next = {pend_reg[WordWidth-5:0], 4'b0000} | digit_val;
                        pending_next = 1'b1;
                    end
                    else if (pending_reg)
                    begin
                        state_next = ST_PUSHNUM;
                    end
                    else
                    begin
                        state_next = ST_RD_A;
                    end
                end
            end
            ST_PUSHNUM:
            begin
                we = 1'b1;
                waddr = to_addr(sp_reg + 8'd1);
                wdata = pend_reg;
                sp_next = sp_reg + 8'd1;
                pend_next = '0;
                pending_next = 1'b0;
                state_next = ST_RD_A;
            end
            ST_RD_A:
            begin
                // Reads the top word; time push needs nothing.
                raddr = to_addr(sp_reg);
                case (tok_reg)
                    OpTime:
                    begin
                        we = 1'b1;
                        waddr = to_addr(sp_reg + 8'd1);
                        wdata = time_reg;
                        sp_next = sp_reg + 8'd1;
                        state_next = ST_IDLE;
                    end
                    OpDrop:
                    begin
                        sp_next = sp_reg - 8'd1;
                        state_next = ST_IDLE;
                    end
                    OpNot, OpDup, OpPick, OpSwap, OpPut, TokEnd:
                        state_next = ST_RD_B;
                    default:
                        state_next = is_binop ? ST_RD_B : ST_IDLE;
                endcase
            end
            ST_RD_B:
            begin
                // rdata holds the top word; fetch the second operand.
                a_next = rdata;
                state_next = ST_EXEC;
                case (tok_reg)
                    OpPut: raddr = to_addr(sp_reg + 8'd1);
                    OpPick: raddr = to_addr(sp_reg - pick_n);
                    default: raddr = to_addr(sp_reg - 8'd1);
                endcase
                if (tok_reg == TokEnd)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_EXEC:
            begin
                b_next = rdata;
                state_next = ST_IDLE;
                case (tok_reg)
                    OpPut:
                    begin
                        we = 1'b1;
                        waddr = to_addr(sp_reg - ptr_t'((a_reg + 32'd1) & ByteMask));
                        wdata = rdata;
                        sp_next = sp_reg - 8'd1;
                    end
                    OpNot:
                    begin
                        we = 1'b1;
                        wdata = ~a_reg;
                    end
                    OpDup:
                    begin
                        we = 1'b1;
                        waddr = to_addr(sp_reg + 8'd1);
                        wdata = a_reg;
                        sp_next = sp_reg + 8'd1;
                    end
                    OpPick:
                    begin
                        we = 1'b1;
                        wdata = rdata;
                    end
                    OpSwap:
                    begin
                        we = 1'b1;
                        waddr = to_addr(sp_reg - 8'd1);
                        wdata = a_reg;
                        state_next = ST_WR2;
                    end
                    OpDiv, OpMod:
                    begin
                        rem_next = '0;
                        quo_next = rdata;
                        cnt_next = '0;
                        state_next = ST_DIV;
                    end
                    default:
                        state_next = ST_WR2;
                endcase
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'd32)
                begin
                    we = 1'b1;
                    sp_next = sp_reg - 8'd1;
                    waddr = to_addr(sp_reg - 8'd1);
                    if (a_reg == '0)
                    begin
                        wdata = '0;
                    end
                    else
                    begin
                        wdata = (tok_reg == OpDiv) ? quo_reg : rem_reg;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                    if (!trial[WordWidth])
                    begin
                        rem_next = trial[WordWidth-1:0];
                        quo_next = {quo_reg[WordWidth-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        quo_next = {quo_reg[WordWidth-2:0], 1'b0};
                    end
                end
            end
            ST_WR2:
            begin
                we = 1'b1;
                state_next = ST_IDLE;
                if (tok_reg == OpSwap)
                begin
                    wdata = b_reg;
                end
                else
                begin
                    waddr = to_addr(sp_reg - 8'd1);
                    wdata = alu;
                    sp_next = sp_reg - 8'd1;
                end
            end
            ST_OUT:
            begin
                // The sample register only changes once the previous word has left.
                if (!oval_reg || out_ch.ready)
                begin
                    oval_next = 1'b1;
                    smp_next = a_reg[7:0];
                    sp_next = '0;
                    pend_next = '0;
                    pending_next = 1'b0;
                    title_next = 1'b1;
                    clr_next = '0;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                we = 1'b1;
                waddr = to_addr(clr_reg);
                wdata = '0;
                clr_next = clr_reg + 8'd1;
                if (clr_reg == ptr_t'(STACK_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_ch.valid = oval_reg;
    assign out_ch.sample = smp_reg;

    // A result only appears right after the end token was handled.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(oval_reg) |-> $past(state_reg) == ST_OUT)
        else $error("sample raised outside the end step");
    // Words are taken only in the idle state.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE)
        else $error("token taken while busy");
    // After the end step the interpreter is back in the title with an empty stack.
    a_reset_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && state_next == ST_CLEAR) |=> (sp_reg == '0 && title_reg))
        else $error("state not cleared after end");

endmodule
`default_nettype wire
